>>> hdl/pft_pkg.sv
`default_nettype none

package pft_pkg;

    localparam int CFG_W   = 11;
    localparam int ADDR_W  = 32;
    localparam int TYPE_W  = 3;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 11;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MARK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GET   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_UNTRACKED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_OOM       = 3'd3;
    localparam logic [STAT_W-1:0] STAT_CORRUPT   = 3'd4;

    localparam logic [TYPE_W-1:0] TYPE_FREE = 3'd0;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] frame_addr;
        logic [TYPE_W-1:0] page_type;
        logic [ADDR_W-1:0] max_addr;
    } pft_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ADDR_W-1:0]  found_addr;
        logic [COUNT_W-1:0] free_count;
    } pft_out_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic start;
        logic restart;
        logic scan;
        logic finish;
    } pft_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic n_zero;
        logic hit;
        logic scan_end;
        logic retry;
        logic out_busy;
    } pft_sts_t;

endpackage

`default_nettype wire

>>> hdl/pft_ctrl.sv
`default_nettype none

module pft_ctrl
    import pft_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire pft_sts_t sts,
    output pft_cmd_t      cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                cmd.start  = 1'b1;
                state_next = sts.n_zero ? S_FINISH : S_SCAN;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.hit) begin
                    state_next = S_FINISH;
                end else if (sts.scan_end) begin
                    // add-free wraps once to slot 0 after the first pass
                    if (sts.retry) begin
                        cmd.restart = 1'b1;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/pft_datapath.sv
`default_nettype none

module pft_datapath
    import pft_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    input  wire pft_in_t          s_item,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output pft_out_t              m_item,
    input  wire pft_cmd_t         cmd,
    output pft_sts_t              sts
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [NW-1:0]    ENTRIES_N = NW'(ENTRIES);
    localparam logic [IDX_W-1:0] IDX_MAX   = IDX_W'(ENTRIES - 1);

    typedef struct packed {
        logic              valid;
        logic [TYPE_W-1:0] ptype;
        logic [ADDR_W-1:0] addr;
    } pft_entry_t;

    pft_entry_t mem [ENTRIES];

    logic [CFG_W-1:0]   cfg_reg;
    pft_in_t            item_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               asc_reg;
    logic               pass1_reg;
    logic               issue_done_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_last_reg;
    pft_entry_t         rdata_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [ADDR_W-1:0]  hit_addr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [IDX_W-1:0]   next_slot_reg;
    pft_out_t           out_reg;
    logic               out_valid_reg;

    logic [NW-1:0]    n_ext;
    logic [NW-1:0]    n_act;
    logic [NW-1:0]    n_m1;
    logic [IDX_W-1:0] n_last;
    logic             slot_in_range;
    logic             issue;
    logic             issue_last;
    logic             match;
    logic             hit;
    logic             count_inc;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    pft_entry_t       mem_wdata;
    pft_out_t         result;

    // active entry count, clamped to the table depth
    assign n_ext         = NW'(cfg_reg);
    assign n_act         = (n_ext >= ENTRIES_N) ? ENTRIES_N : n_ext;
    assign n_m1          = n_act - NW'(1);
    assign n_last        = n_m1[IDX_W-1:0];
    assign slot_in_range = NW'(next_slot_reg) < n_act;

    assign issue      = cmd.scan && !issue_done_reg;
    assign issue_last = asc_reg ? (idx_reg == n_last) : (idx_reg == '0);

    always_comb begin
        match = 1'b0;
        case (item_reg.mode)
            MODE_ADD:  match = !rdata_reg.valid;
            MODE_MARK: match = rdata_reg.valid && (rdata_reg.addr == item_reg.frame_addr);
            MODE_GET:  match = rdata_reg.valid && (rdata_reg.ptype == TYPE_FREE)
                               && (rdata_reg.addr < item_reg.max_addr);
            default:   match = 1'b0;
        endcase
    end

    assign hit       = rd_vld_reg && match;
    assign count_inc = rd_vld_reg && (item_reg.mode == MODE_COUNT) && rdata_reg.valid
                       && (rdata_reg.ptype == TYPE_FREE);

    assign sts.clear_last = idx_reg == IDX_MAX;
    assign sts.n_zero     = n_act == '0;
    assign sts.hit        = hit;
    assign sts.scan_end   = rd_vld_reg && rd_last_reg;
    assign sts.retry      = (item_reg.mode == MODE_ADD) && pass1_reg;
    assign sts.out_busy   = out_valid_reg && !m_ready;

    always_comb begin
        result = '0;
        case (item_reg.mode)
            MODE_ADD: begin
                result.status = found_reg ? STAT_OK : STAT_FULL;
            end
            MODE_MARK: begin
                result.status = found_reg ? STAT_OK : STAT_UNTRACKED;
            end
            MODE_GET: begin
                if (!found_reg) begin
                    result.status = STAT_OOM;
                end else if (hit_addr_reg == '0) begin
                    result.status = STAT_CORRUPT;
                end else begin
                    result.status     = STAT_OK;
                    result.found_addr = hit_addr_reg;
                end
            end
            default: begin
                result.status     = STAT_OK;
                result.free_count = count_reg;
            end
        endcase
    end

    always_comb begin
        mem_we    = cmd.clear || (cmd.finish && found_reg
                    && ((item_reg.mode == MODE_ADD) || (item_reg.mode == MODE_MARK)));
        mem_waddr = cmd.clear ? idx_reg : hit_idx_reg;
        mem_wdata = '0;
        if (!cmd.clear) begin
            mem_wdata.valid = 1'b1;
            if (item_reg.mode == MODE_ADD) begin
                mem_wdata.ptype = TYPE_FREE;
                mem_wdata.addr  = item_reg.frame_addr;
            end else begin
                mem_wdata.ptype = item_reg.page_type;
                mem_wdata.addr  = hit_addr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            rdata_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg        <= '0;
            idx_reg        <= '0;
            asc_reg        <= 1'b1;
            pass1_reg      <= 1'b0;
            issue_done_reg <= 1'b1;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            count_reg      <= '0;
            next_slot_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end

            if (cmd.clear) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end else if (cmd.start) begin
                found_reg      <= 1'b0;
                count_reg      <= '0;
                issue_done_reg <= 1'b0;
                case (item_reg.mode)
                    MODE_ADD: begin
                        idx_reg   <= slot_in_range ? next_slot_reg : '0;
                        pass1_reg <= slot_in_range;
                        asc_reg   <= 1'b1;
                    end
                    MODE_GET: begin
                        idx_reg   <= n_last;
                        pass1_reg <= 1'b0;
                        asc_reg   <= 1'b0;
                    end
                    default: begin
                        idx_reg   <= '0;
                        pass1_reg <= 1'b0;
                        asc_reg   <= 1'b1;
                    end
                endcase
            end else if (cmd.restart) begin
                idx_reg        <= '0;
                pass1_reg      <= 1'b0;
                asc_reg        <= 1'b1;
                issue_done_reg <= 1'b0;
            end else if (issue) begin
                if (issue_last) begin
                    issue_done_reg <= 1'b1;
                end else begin
                    idx_reg <= asc_reg ? idx_reg + IDX_W'(1) : idx_reg - IDX_W'(1);
                end
            end

            rd_vld_reg <= issue;

            if (cmd.scan && hit) begin
                found_reg <= 1'b1;
            end
            if (cmd.scan && count_inc) begin
                count_reg <= count_reg + COUNT_W'(1);
            end

            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
                if (item_reg.mode == MODE_ADD) begin
                    next_slot_reg <= found_reg ? hit_idx_reg : '0;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_item;
        end
        rd_idx_reg  <= idx_reg;
        rd_last_reg <= issue_last;
        if (cmd.scan && hit) begin
            hit_idx_reg  <= rd_idx_reg;
            hit_addr_reg <= rdata_reg.addr;
        end
        if (cmd.finish) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

`default_nettype wire

>>> hdl/page_frame_table.sv
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------
// input     | s_valid / s_ready  | s_item : mode, frame_addr, page_type, max_addr
// result    | m_valid / m_ready  | m_item : status, found_addr, free_count
// config    | cfg_wr_en          | cfg_wr_data : entries_in_use
//
// after reset a clearing pass writes every table entry before the first item
// is taken; config writes are taken during the pass.
// an item's time is set by n = min(entries_in_use, ENTRIES) and the entry scan
// through the single table memory port, one read per cycle; a match ends the
// scan early, and add-free makes a second pass from slot 0 when it wraps.
// a new item is taken while a result still waits in the output register; a stall
// on m_ready holds the next result at its final cycle.
`default_nettype none

module page_frame_table
    import pft_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire pft_in_t          s_item,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output pft_out_t              m_item
);

    pft_cmd_t cmd;
    pft_sts_t sts;

    pft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pft_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

>>> hdl/pft_checker.sv
`default_nettype none

module pft_checker
    import pft_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire pft_out_t m_item
);

    // a result waiting on the output holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // one item at a time: taking an item closes the input
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input stayed open after an item");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.status <= STAT_CORRUPT)
        else $error("status code out of range");

    // only a good get-free carries an address, only count-free a count
    a_fields_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.found_addr != '0 || m_item.free_count != '0)
        |-> m_item.status == STAT_OK
            && (m_item.found_addr == '0 || m_item.free_count == '0))
        else $error("result fields inconsistent with status");

endmodule

bind page_frame_table pft_checker u_pft_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
